// ===== hw/rtl/ade_pkg.sv =====
// Shared types and constants for the two-bus ducking envelope.
`timescale 1ns / 1ps
`default_nettype none
package ade_pkg;

	localparam logic [2:0] REQ_BEGIN   = 3'd0;
	localparam logic [2:0] REQ_END     = 3'd1;
	localparam logic [2:0] REQ_ENABLE  = 3'd2;
	localparam logic [2:0] REQ_DISABLE = 3'd3;
	localparam logic [2:0] REQ_TICK    = 3'd4;

	localparam logic [2:0] CFG_BGM_DUCK_GAIN     = 3'd0;
	localparam logic [2:0] CFG_SFX_DUCK_GAIN     = 3'd1;
	localparam logic [2:0] CFG_BGM_ATTACK_DECAY  = 3'd2;
	localparam logic [2:0] CFG_SFX_ATTACK_DECAY  = 3'd3;
	localparam logic [2:0] CFG_BGM_RELEASE_DECAY = 3'd4;
	localparam logic [2:0] CFG_SFX_RELEASE_DECAY = 3'd5;
	localparam logic [2:0] CFG_BGM_HOLD_MS       = 3'd6;
	localparam logic [2:0] CFG_SFX_HOLD_MS       = 3'd7;

	localparam logic [15:0] UNITY        = 16'd32768;
	localparam logic [15:0] ACTIVE_LIMIT = 16'd32736;
	localparam logic [16:0] ONE_Q16      = 17'h10000;
	localparam logic [7:0]  DT_MAX       = 8'd250;
	localparam logic [7:0]  MAX_NESTING  = 8'd255;

	typedef struct packed {
		logic        ducking;
		logic        hold_done;
		logic        enabled;
		logic [7:0]  dt;
		logic [15:0] user_vol;
	} lane_req_t;

	typedef struct packed {
		logic [15:0] gain;
		logic [15:0] atk_decay;
		logic [15:0] rel_decay;
	} lane_cfg_t;

	typedef struct packed {
		logic        busy;
		logic        written;
		logic [15:0] volume;
		logic [15:0] env;
	} lane_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ade_lane.sv =====
// One bus lane: envelope register, decay power, one-pole step and volume product.
`timescale 1ns / 1ps
`default_nettype none
module ade_lane (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire ade_pkg::lane_req_t req,
	input  wire ade_pkg::lane_cfg_t cfg,
	output ade_pkg::lane_stat_t    stat
);

	localparam logic [2:0] L_IDLE  = 3'd0;
	localparam logic [2:0] L_POW_R = 3'd1;
	localparam logic [2:0] L_POW_B = 3'd2;
	localparam logic [2:0] L_ACC0  = 3'd3;
	localparam logic [2:0] L_ACC1  = 3'd4;
	localparam logic [2:0] L_ENV   = 3'd5;
	localparam logic [2:0] L_VOL   = 3'd6;

	logic [2:0]         state_q;
	ade_pkg::lane_req_t req_q;
	logic [16:0]        r_q;
	logic [16:0]        b_q;
	logic [7:0]         bits_q;
	logic [2:0]         cnt_q;
	logic [33:0]        acc_q;
	logic [15:0]        env_q;
	logic [15:0]        vol_q;
	logic               written_q;

	logic [15:0] target;
	logic [15:0] start_decay;
	logic [16:0] mul_a;
	logic [16:0] mul_b;
	logic [33:0] prod;
	logic [33:0] q16_rnd;
	logic [33:0] vol_rnd;
	logic [17:0] n_raw;
	logic [17:0] n_adj;
	logic [15:0] n_fin;
	logic [16:0] v_raw;
	logic [15:0] v_fin;
	logic        keep;
	logic        step_en;

	assign target      = req_q.ducking ? cfg.gain : ade_pkg::UNITY;
	assign start_decay = req.ducking ? cfg.atk_decay : cfg.rel_decay;
	assign keep        = !req_q.ducking && !req_q.hold_done;
	assign step_en     = req_q.enabled || (env_q < ade_pkg::UNITY);

	always_comb begin
		case (state_q)
			L_POW_R: begin
				mul_a = r_q;
				mul_b = b_q;
			end
			L_POW_B: begin
				mul_a = b_q;
				mul_b = b_q;
			end
			L_ACC0: begin
				mul_a = {1'b0, env_q};
				mul_b = r_q;
			end
			L_ACC1: begin
				mul_a = {1'b0, target};
				mul_b = ade_pkg::ONE_Q16 - r_q;
			end
			L_VOL: begin
				mul_a = {1'b0, req_q.user_vol};
				mul_b = {1'b0, env_q};
			end
			default: begin
				mul_a = 17'd0;
				mul_b = 17'd0;
			end
		endcase
	end

	assign prod    = 34'(mul_a) * 34'(mul_b);
	assign q16_rnd = prod + 34'd32768;
	assign vol_rnd = prod + 34'd16384;
	assign n_raw   = acc_q[33:16];
	assign v_raw   = vol_rnd[31:15];
	assign v_fin   = (v_raw > 17'(ade_pkg::UNITY)) ? ade_pkg::UNITY : v_raw[15:0];

	always_comb begin
		n_adj = n_raw;
		if ((n_raw == 18'(env_q)) && (env_q != target)) begin
			n_adj = (target > env_q) ? 18'(env_q) + 18'd1 : 18'(env_q) - 18'd1;
		end
		n_fin = (n_adj > 18'(ade_pkg::UNITY)) ? ade_pkg::UNITY : n_adj[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= L_IDLE;
			env_q     <= ade_pkg::UNITY;
			written_q <= 1'b0;
		end else begin
			case (state_q)
				L_IDLE: begin
					if (start) begin
						state_q <= L_POW_R;
					end
				end
				L_POW_R: begin
					state_q <= L_POW_B;
				end
				L_POW_B: begin
					state_q <= (cnt_q == 3'd7) ? L_ACC0 : L_POW_R;
				end
				L_ACC0: begin
					state_q <= L_ACC1;
				end
				L_ACC1: begin
					state_q <= L_ENV;
				end
				L_ENV: begin
					written_q <= step_en;
					if (step_en && !keep) begin
						env_q <= n_fin;
					end
					state_q <= L_VOL;
				end
				L_VOL: begin
					state_q <= L_IDLE;
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				if (start) begin
					req_q  <= req;
					r_q    <= ade_pkg::ONE_Q16;
					b_q    <= {1'b0, start_decay};
					bits_q <= req.dt;
					cnt_q  <= 3'd0;
				end
			end
			L_POW_R: begin
				if (bits_q[0]) begin
					r_q <= q16_rnd[32:16];
				end
			end
			L_POW_B: begin
				b_q    <= q16_rnd[32:16];
				bits_q <= {1'b0, bits_q[7:1]};
				cnt_q  <= cnt_q + 3'd1;
			end
			L_ACC0: begin
				acc_q <= prod;
			end
			L_ACC1: begin
				acc_q <= acc_q + q16_rnd;
			end
			L_VOL: begin
				vol_q <= written_q ? v_fin : 16'd0;
			end
			default: begin
			end
		endcase
	end

	assign stat.busy    = (state_q != L_IDLE);
	assign stat.written = written_q;
	assign stat.volume  = vol_q;
	assign stat.env     = env_q;

	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= ade_pkg::UNITY)
		else $error("envelope above unity");

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == L_IDLE) && start |=> (state_q == L_POW_R))
		else $error("lane did not start");

	a_pow_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == L_ACC0) |-> (r_q <= ade_pkg::ONE_Q16))
		else $error("decay power above one");

endmodule
`default_nettype wire

// ===== hw/rtl/ade_merge.sv =====
// Merges the two lane results and the nesting status into the output register.
`timescale 1ns / 1ps
`default_nettype none
module ade_merge (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire logic               tick,
	input  wire logic               nest_nz,
	input  wire ade_pkg::lane_stat_t stat_bgm,
	input  wire ade_pkg::lane_stat_t stat_sfx,
	output logic                    can_load,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// bgm_volume[15:0], sfx_volume[31:16], active[32], zero fill[39:33]
	output logic [39:0]             m_tdata,
	// bgm_written[0], sfx_written[1]
	output logic [1:0]              m_tuser
);

	logic        valid_q;
	logic [39:0] data_q;
	logic [1:0]  user_q;
	logic        bw;
	logic        sw;
	logic        active;

	assign can_load = !valid_q || m_tready;
	assign bw       = tick && stat_bgm.written;
	assign sw       = tick && stat_sfx.written;
	assign active   = (stat_bgm.env < ade_pkg::ACTIVE_LIMIT) ||
	                  (stat_sfx.env < ade_pkg::ACTIVE_LIMIT) || nest_nz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load && can_load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			data_q <= {7'd0, active, (sw ? stat_sfx.volume : 16'd0),
			           (bw ? stat_bgm.volume : 16'd0)};
			user_q <= {sw, bw};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

endmodule
`default_nettype wire

// ===== hw/rtl/audio_ducking_envelope.sv =====
// Top level of the two-bus ducking envelope: request control, configuration and lanes.
// A tick result is offered after eight square-and-multiply steps, each a power-multiply
// state and a base-squaring state, then four step and volume passes and the handoff
// through the run and push states. Other requests go straight to the push state. The
// next input transfer is taken only back in idle, after the last result has been loaded.
// Reset restores the register defaults, full envelopes, zero count and enabled state.
`timescale 1ns / 1ps
`default_nettype none
module audio_ducking_envelope (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// dt_ms[9:0], bgm_user_vol[25:10], sfx_user_vol[41:26], zero fill[47:42]
	input  wire logic [47:0] s_tdata,
	// req_type[2:0]
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// bgm_volume[15:0], sfx_volume[31:16], active[32], zero fill[39:33]
	output logic [39:0]      m_tdata,
	// bgm_written[0], sfx_written[1]
	output logic [1:0]       m_tuser,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_PUSH = 2'd2;

	logic [1:0]  state_q;
	logic        tick_q;
	logic [7:0]  nest_q;
	logic        enabled_q;
	logic [15:0] bgm_hold_q;
	logic [15:0] sfx_hold_q;
	logic [15:0] cfg_q [8];

	logic               accept;
	logic               is_tick;
	logic [9:0]         dt_raw;
	logic [7:0]         dt;
	logic [15:0]        bgm_hold_dn;
	logic [15:0]        sfx_hold_dn;
	logic               can_load;
	ade_pkg::lane_req_t req_bgm;
	ade_pkg::lane_req_t req_sfx;
	ade_pkg::lane_cfg_t cfg_bgm;
	ade_pkg::lane_cfg_t cfg_sfx;
	ade_pkg::lane_stat_t stat_bgm;
	ade_pkg::lane_stat_t stat_sfx;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign is_tick  = (s_tuser == ade_pkg::REQ_TICK);
	assign dt_raw   = s_tdata[9:0];

	always_comb begin
		if (dt_raw == 10'd0) begin
			dt = 8'd1;
		end else if (dt_raw > 10'(ade_pkg::DT_MAX)) begin
			dt = ade_pkg::DT_MAX;
		end else begin
			dt = dt_raw[7:0];
		end
	end

	assign bgm_hold_dn = (bgm_hold_q > 16'(dt)) ? bgm_hold_q - 16'(dt) : 16'd0;
	assign sfx_hold_dn = (sfx_hold_q > 16'(dt)) ? sfx_hold_q - 16'(dt) : 16'd0;

	assign req_bgm.ducking   = enabled_q && (nest_q != 8'd0);
	assign req_bgm.hold_done = (bgm_hold_dn == 16'd0);
	assign req_bgm.enabled   = enabled_q;
	assign req_bgm.dt        = dt;
	assign req_bgm.user_vol  = s_tdata[25:10];
	assign req_sfx.ducking   = enabled_q && (nest_q != 8'd0);
	assign req_sfx.hold_done = (sfx_hold_dn == 16'd0);
	assign req_sfx.enabled   = enabled_q;
	assign req_sfx.dt        = dt;
	assign req_sfx.user_vol  = s_tdata[41:26];

	assign cfg_bgm.gain      = cfg_q[ade_pkg::CFG_BGM_DUCK_GAIN];
	assign cfg_bgm.atk_decay = cfg_q[ade_pkg::CFG_BGM_ATTACK_DECAY];
	assign cfg_bgm.rel_decay = cfg_q[ade_pkg::CFG_BGM_RELEASE_DECAY];
	assign cfg_sfx.gain      = cfg_q[ade_pkg::CFG_SFX_DUCK_GAIN];
	assign cfg_sfx.atk_decay = cfg_q[ade_pkg::CFG_SFX_ATTACK_DECAY];
	assign cfg_sfx.rel_decay = cfg_q[ade_pkg::CFG_SFX_RELEASE_DECAY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[ade_pkg::CFG_BGM_DUCK_GAIN]     <= 16'd8192;
			cfg_q[ade_pkg::CFG_SFX_DUCK_GAIN]     <= 16'd16384;
			cfg_q[ade_pkg::CFG_BGM_ATTACK_DECAY]  <= 16'd64236;
			cfg_q[ade_pkg::CFG_SFX_ATTACK_DECAY]  <= 16'd64236;
			cfg_q[ade_pkg::CFG_BGM_RELEASE_DECAY] <= 16'd65317;
			cfg_q[ade_pkg::CFG_SFX_RELEASE_DECAY] <= 16'd65317;
			cfg_q[ade_pkg::CFG_BGM_HOLD_MS]       <= 16'd150;
			cfg_q[ade_pkg::CFG_SFX_HOLD_MS]       <= 16'd150;
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			tick_q     <= 1'b0;
			nest_q     <= 8'd0;
			enabled_q  <= 1'b1;
			bgm_hold_q <= 16'd0;
			sfx_hold_q <= 16'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						tick_q  <= is_tick;
						state_q <= is_tick ? S_RUN : S_PUSH;
						case (s_tuser)
							ade_pkg::REQ_BEGIN: begin
								if (enabled_q) begin
									if (nest_q == 8'd0) begin
										bgm_hold_q <= cfg_q[ade_pkg::CFG_BGM_HOLD_MS];
										sfx_hold_q <= cfg_q[ade_pkg::CFG_SFX_HOLD_MS];
									end
									if (nest_q < ade_pkg::MAX_NESTING) begin
										nest_q <= nest_q + 8'd1;
									end
								end
							end
							ade_pkg::REQ_END: begin
								if (nest_q != 8'd0) begin
									nest_q <= nest_q - 8'd1;
								end
							end
							ade_pkg::REQ_ENABLE: begin
								enabled_q <= 1'b1;
							end
							ade_pkg::REQ_DISABLE: begin
								enabled_q  <= 1'b0;
								nest_q     <= 8'd0;
								bgm_hold_q <= 16'd0;
								sfx_hold_q <= 16'd0;
							end
							ade_pkg::REQ_TICK: begin
								bgm_hold_q <= bgm_hold_dn;
								sfx_hold_q <= sfx_hold_dn;
							end
							default: begin
							end
						endcase
					end
				end
				S_RUN: begin
					if (!stat_bgm.busy && !stat_sfx.busy) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (can_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	ade_lane u_lane_bgm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && is_tick),
		.req    (req_bgm),
		.cfg    (cfg_bgm),
		.stat   (stat_bgm)
	);

	ade_lane u_lane_sfx (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && is_tick),
		.req    (req_sfx),
		.cfg    (cfg_sfx),
		.stat   (stat_sfx)
	);

	ade_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (state_q == S_PUSH),
		.tick     (tick_q),
		.nest_nz  (nest_q != 8'd0),
		.stat_bgm (stat_bgm),
		.stat_sfx (stat_sfx),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input ready right after a transfer");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH) && can_load |=> m_tvalid)
		else $error("result not offered after push");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while waiting for transfer");

endmodule
`default_nettype wire
